>>> rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table: request and response
// payloads, cell control and flag bundles, status codes and FSM states.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Request action codes (code three behaves as a read)
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  typedef enum logic [2:0] {
    STAT_INSERTED   = 3'd0,
    STAT_DUPLICATE  = 3'd1,
    STAT_DELETED    = 3'd2,
    STAT_NOT_FOUND  = 3'd3,
    STAT_FULL       = 3'd4,
    STAT_READ_OK    = 3'd5,
    STAT_READ_RANGE = 3'd6
  } status_e;

  // Operation broadcast to the cell row
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic [31:0]        payload;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] key_out;
    logic [31:0]        payload_out;
    logic [4:0]         entry_count;
  } rsp_t;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } entry_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctl_t;

  // Registered compare result of one cell
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

>>> rtl/core/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted row. Compares its key against the incoming request,
// then holds, loads the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  logic signed [31:0] cmp_key_i,
  input  logic signed [31:0] new_key_i,
  input  logic [31:0]        new_payload_i,
  input  entry_t             left_i,
  input  entry_t             right_i,
  input  logic               left_lt_i,
  output entry_t             entry_o,
  output cell_flag_t         flag_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] key_q, key_d;
  logic [31:0]        payload_q, payload_d;
  cell_flag_t         flag_q;

  // Next contents for the shift step
  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (!flag_q.lt) begin
          if (left_lt_i) begin
            // first slot not below the new key takes it
            valid_d   = 1'b1;
            key_d     = new_key_i;
            payload_d = new_payload_i;
          end else begin
            valid_d   = left_i.valid;
            key_d     = left_i.key;
            payload_d = left_i.payload;
          end
        end
      end
      OP_DELETE: begin
        if (!flag_q.lt) begin
          valid_d   = right_i.valid;
          key_d     = right_i.key;
          payload_d = right_i.payload;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.cmp_en) begin
        flag_q.lt <= valid_q && (key_q < cmp_key_i);
        flag_q.eq <= valid_q && (key_q == cmp_key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, payload: payload_q};
  assign flag_o  = flag_q;

endmodule

>>> rtl/core/sorted_key_table_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_delete
// Sorted key/payload table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The accept edge latches every cell's compare; the shift step that follows
// applies the row shift and registers the response. A request is taken only
// in idle, so a new one waits until the shift step is done.
// A response held by the sink stalls the shift step, not the compare.
// Reset: control, cell valid bits and occupancy clear at once; no sweep.
module sorted_key_table_insert_delete
  import skt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_e        state_q, state_d;
  req_t          req_q;
  rsp_t          rsp_q, rsp_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW+4:0] count_ext;

  cell_ctl_t             ctl;
  cell_op_e              op;
  entry_t                entries [CAPACITY];
  cell_flag_t            flags   [CAPACITY];
  logic [CAPACITY-1:0]   lt_vec, eq_vec, valid_vec;
  logic                  accept, exec_go, hit, full;
  logic signed [31:0]    rd_key;
  logic [31:0]           rd_payload;

  assign accept  = in_valid_i && in_ready_o;
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC:  if (exec_go)    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctl.cmp_en = 1'b0;
    ctl.op     = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ctl.cmp_en = in_valid_i;
      end
      S_EXEC: begin
        if (exec_go) ctl.op = op;
      end
      default: ;
    endcase
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_lt;
    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_lt = 1'b1;
    end else begin : g_mid
      assign left_e  = entries[i-1];
      assign left_lt = flags[i-1].lt;
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    skt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .cmp_key_i     (in_i.key),
      .new_key_i     (req_q.key),
      .new_payload_i (req_q.payload),
      .left_i        (left_e),
      .right_i       (right_e),
      .left_lt_i     (left_lt),
      .entry_o       (entries[i]),
      .flag_o        (flags[i])
    );

    assign lt_vec[i]    = flags[i].lt;
    assign eq_vec[i]    = flags[i].eq;
    assign valid_vec[i] = entries[i].valid;
  end

  assign hit  = |eq_vec;
  assign full = (count_q == CW'(CAPACITY));

  // Read port: only the first sixteen slots are addressable
  always_comb begin
    rd_key     = '0;
    rd_payload = '0;
    for (int i = 0; i < CAPACITY && i < 16; i++) begin
      if (int'(req_q.position) == i) begin
        rd_key     = entries[i].key;
        rd_payload = entries[i].payload;
      end
    end
  end

  // Decide the operation and build the response
  always_comb begin
    op      = OP_NONE;
    count_d = count_q;
    rsp_d   = '0;
    case (req_q.action)
      ACT_INSERT: begin
        if (hit) begin
          rsp_d.status = STAT_DUPLICATE;
        end else if (full) begin
          rsp_d.status = STAT_FULL;
        end else begin
          op           = OP_INSERT;
          count_d      = count_q + CW'(1);
          rsp_d.status = STAT_INSERTED;
        end
      end
      ACT_DELETE: begin
        if (hit) begin
          op           = OP_DELETE;
          count_d      = count_q - CW'(1);
          rsp_d.status = STAT_DELETED;
        end else begin
          rsp_d.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        if (int'(req_q.position) < int'(count_q)) begin
          rsp_d.status      = STAT_READ_OK;
          rsp_d.key_out     = rd_key;
          rsp_d.payload_out = rd_payload;
        end else begin
          rsp_d.status = STAT_READ_RANGE;
        end
      end
    endcase
    count_ext         = {5'b0, count_d};
    rsp_d.entry_count = count_ext[4:0];
  end

  // Response slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept)  req_q <= in_i;
    if (exec_go) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = rsp_q;

  // Occupancy never exceeds the row length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= CAPACITY)
    else $error("occupancy above capacity");

  // Valid cells match the occupancy count
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("cell valid bits disagree with occupancy");

  // Sorted unique keys: at most one cell matches
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(eq_vec))
    else $error("more than one matching cell");

  // Cells below the new key form a prefix of the row
  a_lt_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> ((lt_vec & (lt_vec + CAPACITY'(1))) == '0))
    else $error("compare flags not a prefix");

  // A shift step always leaves a response waiting
  a_exec_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("shift step did not load a response");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_table_insert_delete. Requests go in over
// a valid/ready channel. A local model of the sorted table predicts each
// response, and the checker compares every response field by field. The
// directed tests cover the empty table, extreme keys and a full table. The
// random tests alternate between fill-heavy and drain-heavy phases, with
// random idle cycles on both sides and one stretch that runs back to back.
// ----------------------------------------------------------------------------
module tb;
  import skt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;

  logic clk_i;
  logic rst_ni       = 1'b0;
  logic in_valid_i   = 1'b0;
  logic in_ready_o;
  req_t in_i         = '0;
  logic out_valid_o;
  logic out_ready_i  = 1'b0;
  rsp_t out_o;

  // Table model state
  logic signed [31:0] table_keys[CAPACITY];
  logic [31:0]        table_payloads[CAPACITY];
  int                 table_fill = 0;

  rsp_t               expected_rsp[$];
  logic signed [31:0] key_pool[POOL_SIZE];
  int                 fail_count  = 0;
  int                 cycle_count = 0;
  bit                 no_idle     = 1'b0;

  sorted_key_table_insert_delete #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the table model and return the response it gives
  function automatic rsp_t apply_request(input req_t r);
    rsp_t rsp;
    int   idx;
    bit   hit;
    rsp = '0;
    idx = 0;
    while (idx < table_fill && $signed(r.key) > table_keys[idx]) idx++;
    hit = (idx < table_fill) && (table_keys[idx] == $signed(r.key));
    case (r.action)
      ACT_INSERT: begin
        if (hit) begin
          rsp.status = STAT_DUPLICATE;
        end else if (table_fill >= CAPACITY) begin
          rsp.status = STAT_FULL;
        end else begin
          for (int j = table_fill; j > idx; j--) begin
            table_keys[j]     = table_keys[j-1];
            table_payloads[j] = table_payloads[j-1];
          end
          table_keys[idx]     = r.key;
          table_payloads[idx] = r.payload;
          table_fill++;
          rsp.status = STAT_INSERTED;
        end
      end
      ACT_DELETE: begin
        if (hit) begin
          for (int j = idx; j + 1 < table_fill; j++) begin
            table_keys[j]     = table_keys[j+1];
            table_payloads[j] = table_payloads[j+1];
          end
          table_fill--;
          rsp.status = STAT_DELETED;
        end else begin
          rsp.status = STAT_NOT_FOUND;
        end
      end
      // read; the unused code behaves the same
      default: begin
        if (int'(r.position) < table_fill) begin
          rsp.key_out     = table_keys[r.position];
          rsp.payload_out = table_payloads[r.position];
          rsp.status      = STAT_READ_OK;
        end else begin
          rsp.status = STAT_READ_RANGE;
        end
      end
    endcase
    rsp.entry_count = table_fill[4:0];
    return rsp;
  endfunction

  function automatic req_t make_req(input logic [1:0] act, input logic signed [31:0] k,
                                    input logic [31:0] p, input logic [3:0] pos);
    req_t r;
    r.action   = act;
    r.key      = k;
    r.payload  = p;
    r.position = pos;
    return r;
  endfunction

  // Drive one request at the falling edge and hold it until accepted
  task automatic send_request(input req_t r);
    while (!no_idle && $urandom_range(99) < 8) @(negedge clk_i);
    in_i       = r;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Response sink with random stalls
  always @(negedge clk_i) begin
    out_ready_i = no_idle || ($urandom_range(99) >= 8);
  end

  // Predict on each accepted request, check each accepted response
  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding: %h", out_o);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_o.status);
            fail_count++;
          end
          if (out_o.key_out !== want.key_out) begin
            $error("key_out: expected %0d, got %0d", want.key_out, out_o.key_out);
            fail_count++;
          end
          if (out_o.payload_out !== want.payload_out) begin
            $error("payload_out: expected %h, got %h", want.payload_out, out_o.payload_out);
            fail_count++;
          end
          if (out_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_o.entry_count);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) expected_rsp.push_back(apply_request(in_i));
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_key_table_insert_delete test failed");
      $finish;
    end
  end

  // Extremes plus a spread of random and near-zero keys
  task automatic refill_key_pool();
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) begin
      if ($urandom_range(1)) key_pool[i] = $urandom;
      else key_pool[i] = $signed($urandom_range(40)) - 20;
    end
  endtask

  function automatic logic signed [31:0] pick_key(input int present_pct);
    if (table_fill > 0 && $urandom_range(99) < present_pct)
      return table_keys[$urandom_range(table_fill - 1)];
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic test_empty_table();
    send_request(make_req(ACT_READ, 0, 0, 4'd0));
    send_request(make_req(2'd3, -1, '1, 4'd15));
    send_request(make_req(ACT_DELETE, 32'sh8000_0000, 0, 4'd0));
  endtask

  task automatic test_extreme_keys();
    send_request(make_req(ACT_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 4'd0));
    send_request(make_req(ACT_INSERT, 32'sh8000_0000, 32'h0000_0000, 4'd15));
    send_request(make_req(ACT_INSERT, 0, 32'ha5a5_5a5a, 4'd0));
    send_request(make_req(ACT_INSERT, -1, 32'h5a5a_a5a5, 4'd0));
    send_request(make_req(ACT_INSERT, 32'sh8000_0000, 32'h1234_5678, 4'd0));
    send_request(make_req(ACT_READ, 0, 0, 4'd0));
    send_request(make_req(ACT_DELETE, 32'sh7fff_ffff, 0, 4'd0));
    send_request(make_req(ACT_DELETE, 32'sh7fff_ffff, 0, 4'd0));
  endtask

  // Fill to capacity, then hit the full and duplicate-while-full cases
  task automatic test_full_table();
    int k;
    k = 0;
    while (table_fill < CAPACITY) begin
      send_request(make_req(ACT_INSERT, k * 1000 + 7, $urandom, 4'd0));
      k++;
    end
    send_request(make_req(ACT_INSERT, 32'sh4000_0000, $urandom, 4'd0));
    send_request(make_req(ACT_INSERT, 0, $urandom, 4'd0));
    send_request(make_req(ACT_READ, 0, 0, 4'd15));
  endtask

  // Random phases that alternately lean toward filling and draining
  task automatic test_random_mix(input int n_items);
    int   done;
    bit   fill_phase;
    int   roll;
    int   ins_pct;
    req_t r;
    done       = 0;
    fill_phase = 1'b0;
    while (done < n_items) begin
      refill_key_pool();
      ins_pct = fill_phase ? 60 : 25;
      for (int i = 0; i < 50 && done < n_items; i++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          r = make_req(2'($urandom_range(3)), $urandom, $urandom, 4'($urandom_range(15)));
        end else if (roll < 5 + ins_pct) begin
          r = make_req(ACT_INSERT, pick_key(15), $urandom, 4'($urandom_range(15)));
        end else if (roll < 5 + ins_pct + 45) begin
          r = make_req(ACT_DELETE, pick_key(70), $urandom, 4'($urandom_range(15)));
        end else begin
          r = make_req(($urandom_range(9) == 0) ? 2'd3 : ACT_READ, $urandom, $urandom,
                       4'((table_fill > 0 && $urandom_range(4) != 0) ?
                          $urandom_range(table_fill - 1) : $urandom_range(15)));
        end
        send_request(r);
        done++;
      end
      fill_phase = ~fill_phase;
    end
  endtask

  // Same mix with no idle cycles on either side
  task automatic test_back_to_back(input int n_items);
    no_idle = 1'b1;
    test_random_mix(n_items);
    no_idle = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_extreme_keys();
    test_full_table();
    test_random_mix(500);
    test_back_to_back(150);
    test_random_mix(300);
    wait_for_drain();
    if (fail_count == 0) begin
      $display("sorted_key_table_insert_delete test passed");
    end else begin
      $display("sorted_key_table_insert_delete test failed");
    end
    $finish;
  end

endmodule
